// ===== rtl/smf_pkg.sv =====
package smf_pkg;

	localparam int DATA_W     = 16;
	localparam int POS_W      = 12;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [POS_W-1:0] SCAN_LENGTH_RESET = 12'd361;

	// register index, taken from paddr[2]
	localparam logic REG_SCAN_LENGTH = 1'b0;

	typedef logic [DATA_W-1:0] sample_t;
	typedef logic [POS_W-1:0]  pos_t;

	typedef struct packed {
		pos_t pos;
		logic last;
	} job_t;

endpackage

// ===== rtl/sliding_median_filter_top.sv =====
// Running median filter over a lidar scan of scan_length range samples (mm).
// Result k is the median of samples k-HALF..k+HALF (HALF = WINDOW/2) and
// leaves once sample k+HALF has been transferred; the first and last HALF
// results of a scan are the raw samples. A row of 2*HALF+1 sorting cells holds
// the window in order and replaces its oldest entry with each new sample, so a
// sample that yields at most one result is taken every cycle while the result
// side does not stall; its result passes the job registers, then the result
// register. The last sample of a scan at position p flushes min(p, HALF)+1
// results, one per cycle unless the result side stalls, and holds the sample
// input until the last of them is loaded. Writing scan_length restarts the scan.
module sliding_median_filter_top #(
	parameter int WINDOW = 15
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [smf_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [smf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [smf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic [smf_pkg::DATA_W-1:0]         range_mm,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [smf_pkg::DATA_W-1:0]         filtered_range_mm,
	output logic [smf_pkg::POS_W-1:0]          sample_index,
	output logic                               last_of_scan
);

	localparam int HALF  = WINDOW / 2;
	localparam int SPAN  = 2 * HALF + 1;
	localparam int AGE_W = $clog2(SPAN);
	localparam int BW    = (HALF + 1 > 1) ? $clog2(HALF + 1) : 1;

	smf_pkg::pos_t    scan_length_q;
	smf_pkg::pos_t    pos_q;
	smf_pkg::sample_t tap_q [HALF+1];

	logic                  cfg_wr;
	logic                  accept;
	logic                  hold;
	logic [BW-1:0]         rd_back;
	smf_pkg::sample_t      tap_val;
	smf_pkg::job_t         job;
	logic [smf_pkg::POS_W:0] len_eff;

	smf_pkg::sample_t      val_ext [SPAN+2];
	logic [AGE_W-1:0]      age_ext [SPAN+2];
	logic                  gt_ext  [SPAN+2];
	logic                  old_seen [SPAN+1];
	logic [SPAN-1:0]       is_old;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == smf_pkg::REG_SCAN_LENGTH);
	assign prdata = (paddr[2] == smf_pkg::REG_SCAN_LENGTH) ?
		smf_pkg::APB_DATA_W'(scan_length_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_length_q <= smf_pkg::SCAN_LENGTH_RESET;
		end else if (cfg_wr) begin
			scan_length_q <= pwdata[smf_pkg::POS_W-1:0];
		end
	end

	// scan position
	assign accept       = sample_valid && !hold;
	assign sample_stall = hold;
	assign len_eff      = (scan_length_q == '0) ? (smf_pkg::POS_W+1)'(1) :
		{1'b0, scan_length_q};
	assign job.pos      = pos_q;
	assign job.last     = ({1'b0, pos_q} + (smf_pkg::POS_W+1)'(1)) >= len_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cfg_wr) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= job.last ? '0 : pos_q + smf_pkg::POS_W'(1);
		end
	end

	// raw delay line, newest first
	always_ff @(posedge clk) begin
		if (accept) begin
			tap_q[0] <= range_mm;
			for (int j = 1; j <= HALF; j++) begin
				tap_q[j] <= tap_q[j-1];
			end
		end
	end

	assign tap_val = (int'(rd_back) <= HALF) ? tap_q[rd_back] : '0;

	// sorted cell row
	assign val_ext[0]      = '0;
	assign age_ext[0]      = '0;
	assign gt_ext[0]       = 1'b0;
	assign val_ext[SPAN+1] = '0;
	assign age_ext[SPAN+1] = '0;
	assign gt_ext[SPAN+1]  = 1'b1;
	assign old_seen[0]     = 1'b0;

	for (genvar i = 0; i < SPAN; i++) begin : g_cell
		smf_cell #(
			.AGE_W    (AGE_W),
			.OLDEST   (SPAN - 1),
			.RESET_AGE(i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.shift_en    (accept),
			.new_val     (range_mm),
			.left_val    (val_ext[i]),
			.left_age    (age_ext[i]),
			.left_gt     (gt_ext[i]),
			.right_val   (val_ext[i+2]),
			.right_age   (age_ext[i+2]),
			.right_gt    (gt_ext[i+2]),
			.old_seen_in (old_seen[i]),
			.val         (val_ext[i+1]),
			.age         (age_ext[i+1]),
			.gt          (gt_ext[i+1]),
			.is_old      (is_old[i]),
			.old_seen_out(old_seen[i+1])
		);
	end

	smf_emit #(
		.HALF(HALF),
		.BW  (BW)
	) u_emit (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.job              (job),
		.hold             (hold),
		.rd_back          (rd_back),
		.tap_val          (tap_val),
		.median           (val_ext[HALF+1]),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.filtered_range_mm(filtered_range_mm),
		.sample_index     (sample_index),
		.last_of_scan     (last_of_scan)
	);

`ifndef SYNTH
	a_one_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(is_old))
		else $error("cell row does not hold exactly one oldest entry");

	a_oldest_reached: assert property (@(posedge clk) disable iff (!arst_n)
		old_seen[SPAN])
		else $error("no oldest entry found along the cell row");

	a_sorted_centre: assert property (@(posedge clk) disable iff (!arst_n)
		val_ext[HALF] <= val_ext[HALF+1] && val_ext[HALF+1] <= val_ext[HALF+2])
		else $error("cell row out of order around the median");

	a_scan_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && job.last |=> pos_q == '0)
		else $error("position not cleared after last sample of scan");
`endif

endmodule

// ===== rtl/smf_cell.sv =====
module smf_cell #(
	parameter int AGE_W     = 4,
	parameter int OLDEST    = 14,
	parameter int RESET_AGE = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift_en,
	input  smf_pkg::sample_t      new_val,
	input  smf_pkg::sample_t      left_val,
	input  logic [AGE_W-1:0]      left_age,
	input  logic                  left_gt,
	input  smf_pkg::sample_t      right_val,
	input  logic [AGE_W-1:0]      right_age,
	input  logic                  right_gt,
	input  logic                  old_seen_in,
	output smf_pkg::sample_t      val,
	output logic [AGE_W-1:0]      age,
	output logic                  gt,
	output logic                  is_old,
	output logic                  old_seen_out
);

	smf_pkg::sample_t  val_q;
	logic [AGE_W-1:0]  age_q;
	smf_pkg::sample_t  val_d;
	logic [AGE_W-1:0]  age_d;

	assign gt           = val_q > new_val;
	assign is_old       = age_q == AGE_W'(OLDEST);
	assign old_seen_out = old_seen_in | is_old;
	assign val          = val_q;
	assign age          = age_q;

	// oldest entry leaves, new sample goes in at its sorted place
	always_comb begin
		val_d = val_q;
		age_d = age_q + AGE_W'(1);
		if (is_old) begin
			if (left_gt) begin
				val_d = left_val;
				age_d = left_age + AGE_W'(1);
			end else if (!right_gt) begin
				val_d = right_val;
				age_d = right_age + AGE_W'(1);
			end else begin
				val_d = new_val;
				age_d = '0;
			end
		end else if (old_seen_in) begin
			if (!right_gt) begin
				val_d = right_val;
				age_d = right_age + AGE_W'(1);
			end else if (!gt) begin
				val_d = new_val;
				age_d = '0;
			end
		end else begin
			if (left_gt) begin
				val_d = left_val;
				age_d = left_age + AGE_W'(1);
			end else if (gt) begin
				val_d = new_val;
				age_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			age_q <= AGE_W'(RESET_AGE);
		end else if (shift_en) begin
			val_q <= val_d;
			age_q <= age_d;
		end
	end

endmodule

// ===== rtl/smf_emit.sv =====
module smf_emit #(
	parameter int HALF = 7,
	parameter int BW   = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  smf_pkg::job_t     job,
	output logic              hold,
	output logic [BW-1:0]     rd_back,
	input  smf_pkg::sample_t  tap_val,
	input  smf_pkg::sample_t  median,
	output logic              result_valid,
	input  logic              result_stall,
	output smf_pkg::sample_t  filtered_range_mm,
	output smf_pkg::pos_t     sample_index,
	output logic              last_of_scan
);

	localparam logic [BW-1:0] CENTRE       = BW'(HALF);
	localparam smf_pkg::pos_t HALF_POS     = smf_pkg::POS_W'(HALF);
	localparam smf_pkg::pos_t TWO_HALF_POS = smf_pkg::POS_W'(2 * HALF);

	logic             busy_q;
	logic [BW-1:0]    back_q;
	smf_pkg::pos_t    k_q;
	logic             last_q;
	logic             med_ok_q;
	logic             res_valid_q;
	smf_pkg::sample_t res_val_q;
	smf_pkg::pos_t    res_idx_q;
	logic             res_last_q;

	logic             emits;
	logic [BW-1:0]    start_back;
	logic [BW-1:0]    end_back;
	logic             load;
	logic             done;

	assign emits      = job.last || (job.pos >= HALF_POS);
	assign start_back = (job.last && (job.pos < HALF_POS)) ? job.pos[BW-1:0] : CENTRE;
	assign end_back   = last_q ? '0 : CENTRE;
	assign load       = busy_q && (!res_valid_q || !result_stall);
	assign done       = load && (back_q == end_back);
	assign hold       = busy_q && !done;
	assign rd_back    = back_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			back_q   <= '0;
			k_q      <= '0;
			last_q   <= 1'b0;
			med_ok_q <= 1'b0;
		end else if (accept) begin
			busy_q   <= emits;
			back_q   <= start_back;
			k_q      <= job.pos - smf_pkg::POS_W'(start_back);
			last_q   <= job.last;
			med_ok_q <= job.pos >= TWO_HALF_POS;
		end else if (load) begin
			if (done) begin
				busy_q <= 1'b0;
			end else begin
				back_q <= back_q - BW'(1);
				k_q    <= k_q + smf_pkg::POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_val_q  <= ((back_q == CENTRE) && med_ok_q) ? median : tap_val;
			res_idx_q  <= k_q;
			res_last_q <= last_q && (back_q == '0);
		end
	end

	assign result_valid      = res_valid_q;
	assign filtered_range_mm = res_val_q;
	assign sample_index      = res_idx_q;
	assign last_of_scan      = res_last_q;

`ifndef SYNTH
	a_back_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> back_q <= CENTRE)
		else $error("tap index beyond window half");

	a_mid_scan_centre_only: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !last_q |-> back_q == CENTRE)
		else $error("mid-scan job left the centre tap");

	a_no_result_early: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !job.last && (job.pos < HALF_POS) |=> !busy_q)
		else $error("result started for a sample with none due");
`endif

endmodule
